FILE: design/pmd_pkg.sv
// Shared types, widths, register indexes and reset values for the PID motor drive unit.
package pmd_pkg;

  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned LIM_W      = 12;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned ERR_W      = 17;
  localparam int unsigned DER_W      = 18;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned PROD_W     = 56;
  localparam int unsigned ACC_W      = 58;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned TRUNC_W    = ACC_W - FRAC_W;
  localparam int unsigned DIFF_W     = 13;
  localparam int unsigned NUM_W      = 26;
  localparam int unsigned MAG_W      = 25;
  localparam int unsigned DRV_W      = 27;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned MUL_STEPS  = 3;
  localparam int unsigned DIV_STEPS  = MAG_W;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_IN_LOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_AT_LOW  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_AT_HIGH = 3'd7;

  localparam logic [GAIN_W-1:0] GAIN_P_RST      = 24'd32792;
  localparam logic [GAIN_W-1:0] GAIN_I_RST      = 24'd2739;
  localparam logic [GAIN_W-1:0] GAIN_D_RST      = 24'd0;
  localparam logic [LIM_W-1:0]  CLAMP_LOW_RST   = 12'd1;
  localparam logic [LIM_W-1:0]  CLAMP_HIGH_RST  = 12'd3190;
  localparam logic [LIM_W-1:0]  MAP_IN_LOW_RST  = 12'd0;
  localparam logic [LIM_W-1:0]  OUT_AT_LOW_RST  = 12'd3190;
  localparam logic [LIM_W-1:0]  OUT_AT_HIGH_RST = 12'd1;

  localparam logic [LIM_W-1:0] DRIVE_MAX = 12'd4095;

  typedef struct packed {
    logic                    operation;
    logic signed [VAL_W-1:0] reference;
    logic signed [VAL_W-1:0] measured;
  } in_item_t;

  typedef struct packed {
    logic [LIM_W-1:0] drive;
    logic             stop;
  } out_item_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [LIM_W-1:0]         clamp_low;
    logic [LIM_W-1:0]         clamp_high;
    logic [LIM_W-1:0]         map_in_low;
    logic [LIM_W-1:0]         out_at_low;
    logic [LIM_W-1:0]         out_at_high;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_CLAMP,
    ST_SCALE,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_P = 2'd0,
    MUL_I = 2'd1,
    MUL_D = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_en;
    logic     clamp_en;
    logic     scale_en;
    logic     div_en;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

FILE: design/pid_motor_drive_unit.sv
// Top level of the PID motor drive unit: configuration registers, sequencer and datapath.
//
// One PID update per input item. An item (operation, reference, measured) is taken
// when in_valid_i is high and in_stall_o is low; in_stall_o is low only while the
// unit is idle. Each item yields exactly one result (drive, stop), offered on
// out_valid_o and taken at an edge where out_stall_i is low.
// Sequence: after its item is taken, the P, I and D terms go in turn through the
// shared 24x32 gain multiplier; the accumulation is finished, the sum is truncated
// and clamped, the remap product is formed, 25 steps of the bit-serial remap divider
// run, and the offset and saturation are applied as the result enters the output
// register. The next item can be taken in the cycle after the result enters it.
// A result waiting in the output register does not block the next item; only a
// second result that finds the register still full waits in the final step.
// Configuration writes go through cfg_valid_i / cfg_ready_o (always ready), register
// index on cfg_index_i, data on cfg_data_i, truncated to the register's width.
// Reset loads the register reset values and clears the error sum, the last error
// and the output valid flag.
module pid_motor_drive_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  pmd_pkg::in_item_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output pmd_pkg::out_item_t                   out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pmd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [pmd_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  pmd_pkg::cfg_t    cfg_q;
  pmd_pkg::cmd_t    cmd;
  pmd_pkg::status_t status;

  // Writes must be issued only while idle (not enforced); the register file never stalls
  assign cfg_ready_o = 1'b1;

  // Register file: hold each field at its own width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p      <= pmd_pkg::GAIN_P_RST;
      cfg_q.gain_i      <= pmd_pkg::GAIN_I_RST;
      cfg_q.gain_d      <= pmd_pkg::GAIN_D_RST;
      cfg_q.clamp_low   <= pmd_pkg::CLAMP_LOW_RST;
      cfg_q.clamp_high  <= pmd_pkg::CLAMP_HIGH_RST;
      cfg_q.map_in_low  <= pmd_pkg::MAP_IN_LOW_RST;
      cfg_q.out_at_low  <= pmd_pkg::OUT_AT_LOW_RST;
      cfg_q.out_at_high <= pmd_pkg::OUT_AT_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pmd_pkg::REG_GAIN_P:      cfg_q.gain_p      <= cfg_data_i;
        pmd_pkg::REG_GAIN_I:      cfg_q.gain_i      <= cfg_data_i;
        pmd_pkg::REG_GAIN_D:      cfg_q.gain_d      <= cfg_data_i;
        pmd_pkg::REG_CLAMP_LOW:   cfg_q.clamp_low   <= cfg_data_i[pmd_pkg::LIM_W-1:0];
        pmd_pkg::REG_CLAMP_HIGH:  cfg_q.clamp_high  <= cfg_data_i[pmd_pkg::LIM_W-1:0];
        pmd_pkg::REG_MAP_IN_LOW:  cfg_q.map_in_low  <= cfg_data_i[pmd_pkg::LIM_W-1:0];
        pmd_pkg::REG_OUT_AT_LOW:  cfg_q.out_at_low  <= cfg_data_i[pmd_pkg::LIM_W-1:0];
        pmd_pkg::REG_OUT_AT_HIGH: cfg_q.out_at_high <= cfg_data_i[pmd_pkg::LIM_W-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // Sequencer: accept, step the multiplier and divider, release the result
  pmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: error state, gain products, clamp, remap and output register
  pmd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/pmd_ctrl.sv
// Sequencer for the PID motor drive unit: steps one item through multiply, clamp and divide.
module pmd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pmd_pkg::status_t status_i,
  output pmd_pkg::cmd_t    cmd_o
);

  pmd_pkg::state_e state_q, state_d;
  logic [pmd_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic mul_last, div_last;

  assign mul_last = (cnt_q == pmd_pkg::CNT_W'(pmd_pkg::MUL_STEPS - 1));
  assign div_last = (cnt_q == pmd_pkg::CNT_W'(pmd_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pmd_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and step counter
  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    case (state_q)
      pmd_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = pmd_pkg::ST_MUL;
      end
      pmd_pkg::ST_MUL: begin
        if (mul_last) state_d = pmd_pkg::ST_ACC;
        else cnt_d = cnt_q + 1'b1;
      end
      pmd_pkg::ST_ACC:   state_d = pmd_pkg::ST_CLAMP;
      pmd_pkg::ST_CLAMP: state_d = pmd_pkg::ST_SCALE;
      pmd_pkg::ST_SCALE: state_d = pmd_pkg::ST_DIV;
      pmd_pkg::ST_DIV: begin
        if (div_last) state_d = pmd_pkg::ST_DONE;
        else cnt_d = cnt_q + 1'b1;
      end
      pmd_pkg::ST_DONE: begin
        if (status_i.out_free) state_d = pmd_pkg::ST_IDLE;
      end
      default: state_d = pmd_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      pmd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      pmd_pkg::ST_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pmd_pkg::mul_sel_e'(cnt_q[1:0]);
        cmd_o.acc_en  = (cnt_q != '0);
      end
      pmd_pkg::ST_ACC:   cmd_o.acc_en   = 1'b1;
      pmd_pkg::ST_CLAMP: cmd_o.clamp_en = 1'b1;
      pmd_pkg::ST_SCALE: cmd_o.scale_en = 1'b1;
      pmd_pkg::ST_DIV:   cmd_o.div_en   = 1'b1;
      pmd_pkg::ST_DONE:  cmd_o.out_load = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: design/pmd_datapath.sv
// Datapath of the PID motor drive unit: error state, shared multiplier, clamp, remap divider.
module pmd_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pmd_pkg::cfg_t      cfg_i,
  input  pmd_pkg::in_item_t  in_data_i,
  input  pmd_pkg::cmd_t      cmd_i,
  output pmd_pkg::status_t   status_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pmd_pkg::out_item_t out_data_o
);

  localparam int unsigned EXT_E = pmd_pkg::SUM_W - pmd_pkg::ERR_W;
  localparam int unsigned EXT_D = pmd_pkg::SUM_W - pmd_pkg::DER_W;
  localparam int unsigned EXT_P = pmd_pkg::ACC_W - pmd_pkg::PROD_W;
  localparam int unsigned EXT_A = pmd_pkg::PROD_W - pmd_pkg::GAIN_W;
  localparam int unsigned EXT_B = pmd_pkg::PROD_W - pmd_pkg::SUM_W;
  localparam int unsigned EXT_N = pmd_pkg::NUM_W - pmd_pkg::DIFF_W;
  localparam int unsigned EXT_L = pmd_pkg::TRUNC_W - pmd_pkg::LIM_W;
  localparam int unsigned EXT_Q = pmd_pkg::DRV_W - pmd_pkg::MAG_W;
  localparam int unsigned EXT_O = pmd_pkg::DRV_W - pmd_pkg::LIM_W;

  // Persistent controller state
  logic signed [pmd_pkg::SUM_W-1:0] error_sum_q;
  logic signed [pmd_pkg::ERR_W-1:0] last_error_q;

  // Per-item working registers
  logic signed [pmd_pkg::ERR_W-1:0]   err_q;
  logic signed [pmd_pkg::SUM_W-1:0]   sum_q;
  logic signed [pmd_pkg::DER_W-1:0]   deriv_q;
  logic                               stop_q;
  logic signed [pmd_pkg::PROD_W-1:0]  prod_q;
  logic signed [pmd_pkg::ACC_W-1:0]   acc_q;
  logic [pmd_pkg::LIM_W-1:0]          v_q;
  logic [pmd_pkg::MAG_W-1:0]          quo_q;
  logic [pmd_pkg::LIM_W-1:0]          rem_q;
  logic [pmd_pkg::LIM_W-1:0]          dvs_q;
  logic                               neg_q;
  logic                               den_zero_q;
  logic                               out_valid_q;
  pmd_pkg::out_item_t                 out_data_q;

  // Error, saturated sum, derivative
  logic signed [pmd_pkg::ERR_W-1:0] err;
  logic signed [pmd_pkg::SUM_W:0]   sum_wide;
  logic signed [pmd_pkg::SUM_W-1:0] sum_sat;
  logic signed [pmd_pkg::DER_W-1:0] deriv;

  assign err = $signed({in_data_i.reference[pmd_pkg::VAL_W-1], in_data_i.reference})
             - $signed({in_data_i.measured[pmd_pkg::VAL_W-1], in_data_i.measured});
  assign sum_wide = $signed({error_sum_q[pmd_pkg::SUM_W-1], error_sum_q})
                  + $signed({{(pmd_pkg::SUM_W + 1 - pmd_pkg::ERR_W){err[pmd_pkg::ERR_W-1]}}, err});
  assign deriv = $signed({err[pmd_pkg::ERR_W-1], err})
               - $signed({last_error_q[pmd_pkg::ERR_W-1], last_error_q});

  always_comb begin
    if (sum_wide[pmd_pkg::SUM_W] != sum_wide[pmd_pkg::SUM_W-1]) begin
      sum_sat = sum_wide[pmd_pkg::SUM_W] ? {1'b1, {(pmd_pkg::SUM_W-1){1'b0}}}
                                         : {1'b0, {(pmd_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[pmd_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q  <= '0;
      last_error_q <= '0;
    end else if (cmd_i.load) begin
      error_sum_q  <= sum_sat;
      last_error_q <= err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q   <= err;
      sum_q   <= sum_sat;
      deriv_q <= deriv;
      stop_q  <= in_data_i.operation && (in_data_i.measured >= in_data_i.reference);
    end
  end

  // Shared multiplier: one gain term per cycle
  logic signed [pmd_pkg::GAIN_W-1:0] mul_a;
  logic signed [pmd_pkg::SUM_W-1:0]  mul_b;

  always_comb begin
    case (cmd_i.mul_sel)
      pmd_pkg::MUL_P: begin
        mul_a = cfg_i.gain_p;
        mul_b = $signed({{EXT_E{err_q[pmd_pkg::ERR_W-1]}}, err_q});
      end
      pmd_pkg::MUL_I: begin
        mul_a = cfg_i.gain_i;
        mul_b = sum_q;
      end
      pmd_pkg::MUL_D: begin
        mul_a = cfg_i.gain_d;
        mul_b = $signed({{EXT_D{deriv_q[pmd_pkg::DER_W-1]}}, deriv_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= $signed({{EXT_A{mul_a[pmd_pkg::GAIN_W-1]}}, mul_a})
              * $signed({{EXT_B{mul_b[pmd_pkg::SUM_W-1]}}, mul_b});
    end
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + $signed({{EXT_P{prod_q[pmd_pkg::PROD_W-1]}}, prod_q});
    end
  end

  // Truncate toward zero, then clamp with the low bound tested first
  logic signed [pmd_pkg::ACC_W-1:0]   acc_adj;
  logic signed [pmd_pkg::TRUNC_W-1:0] v_full;
  logic signed [pmd_pkg::TRUNC_W-1:0] lo_ext, hi_ext;
  logic [pmd_pkg::LIM_W-1:0]          v_clamp;

  assign acc_adj = acc_q[pmd_pkg::ACC_W-1]
                 ? acc_q + $signed({{(pmd_pkg::ACC_W-pmd_pkg::FRAC_W){1'b0}},
                                    {pmd_pkg::FRAC_W{1'b1}}})
                 : acc_q;
  assign v_full = acc_adj[pmd_pkg::ACC_W-1:pmd_pkg::FRAC_W];
  assign lo_ext = $signed({{EXT_L{1'b0}}, cfg_i.clamp_low});
  assign hi_ext = $signed({{EXT_L{1'b0}}, cfg_i.clamp_high});

  always_comb begin
    if (v_full < lo_ext)      v_clamp = cfg_i.clamp_low;
    else if (v_full > hi_ext) v_clamp = cfg_i.clamp_high;
    else                      v_clamp = v_full[pmd_pkg::LIM_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clamp_en) v_q <= v_clamp;
  end

  // Remap numerator and divisor, sign-magnitude form
  logic signed [pmd_pkg::DIFF_W-1:0] diff_in, diff_out, den;
  logic signed [pmd_pkg::NUM_W-1:0]  num, num_abs;
  logic signed [pmd_pkg::DIFF_W-1:0] den_abs;

  assign diff_in  = $signed({1'b0, v_q}) - $signed({1'b0, cfg_i.map_in_low});
  assign diff_out = $signed({1'b0, cfg_i.out_at_high}) - $signed({1'b0, cfg_i.out_at_low});
  assign den      = $signed({1'b0, cfg_i.clamp_high}) - $signed({1'b0, cfg_i.map_in_low});
  assign num      = $signed({{EXT_N{diff_in[pmd_pkg::DIFF_W-1]}}, diff_in})
                  * $signed({{EXT_N{diff_out[pmd_pkg::DIFF_W-1]}}, diff_out});
  assign num_abs  = num[pmd_pkg::NUM_W-1] ? -num : num;
  assign den_abs  = den[pmd_pkg::DIFF_W-1] ? -den : den;

  // Restoring divider: one quotient bit per step
  logic [pmd_pkg::LIM_W:0] rem_sh, rem_sub;

  assign rem_sh  = {rem_q, quo_q[pmd_pkg::MAG_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_en) begin
      quo_q      <= num_abs[pmd_pkg::MAG_W-1:0];
      rem_q      <= '0;
      dvs_q      <= den_abs[pmd_pkg::LIM_W-1:0];
      neg_q      <= num[pmd_pkg::NUM_W-1] ^ den[pmd_pkg::DIFF_W-1];
      den_zero_q <= (den == '0);
    end else if (cmd_i.div_en) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_q <= rem_sub[pmd_pkg::LIM_W-1:0];
        quo_q <= {quo_q[pmd_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[pmd_pkg::LIM_W-1:0];
        quo_q <= {quo_q[pmd_pkg::MAG_W-2:0], 1'b0};
      end
    end
  end

  // Offset and saturate the drive value
  logic signed [pmd_pkg::DRV_W-1:0] q_pos, q_signed, drive_w;
  logic [pmd_pkg::LIM_W-1:0]        drive;

  assign q_pos    = $signed({{EXT_Q{1'b0}}, quo_q});
  assign q_signed = neg_q ? -q_pos : q_pos;
  assign drive_w  = q_signed + $signed({{EXT_O{1'b0}}, cfg_i.out_at_low});

  always_comb begin
    if (den_zero_q)              drive = cfg_i.out_at_low;
    else if (drive_w < 0)        drive = '0;
    else if (drive_w > $signed({{EXT_O{1'b0}}, pmd_pkg::DRIVE_MAX}))
                                 drive = pmd_pkg::DRIVE_MAX;
    else                         drive = drive_w[pmd_pkg::LIM_W-1:0];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.drive <= drive;
      out_data_q.stop  <= stop_q;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

endmodule
